/* hdl/qnl_pkg.sv */
// Shared widths, payload types and constants for the quaternion nlerp pipeline.
package qnl_pkg;

    localparam int CW        = 16;
    localparam int TW        = 17;
    localparam int CFB       = 14;
    localparam int WFB       = 16;
    localparam int GUARD     = 8;
    localparam int SH        = WFB - GUARD;
    localparam int PW        = TW + CW + 1;
    localparam int BW        = PW + 1;
    localparam int DW        = 2 * CW + 2;
    localparam int BMW       = CW + WFB;
    localparam int MAGW      = BMW - SH;
    localparam int SQW       = 2 * MAGW + 2;
    localparam int ISQ_STEPS = SQW / 2;
    localparam int LENW      = ISQ_STEPS;
    localparam int REMW      = LENW + 2;
    localparam int QW        = CFB + 1;

    typedef logic [3:0][MAGW-1:0] t_mags;
    typedef logic [3:0][QW-1:0]   t_quots;

    typedef struct packed {
        logic                bypass;
        logic [3:0][CW-1:0]  byp;
        logic [3:0]          neg;
    } t_side_div;

    typedef struct packed {
        t_side_div d;
        t_mags     mag;
    } t_side_sq;

endpackage

/* hdl/qnl_isqrt.sv */
// Pipelined floor square root, one root bit per stage, with sideband carried alongside.
module qnl_isqrt (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_ce,
    input  logic                       i_valid,
    input  logic [qnl_pkg::SQW-1:0]    i_val,
    input  qnl_pkg::t_side_sq          i_side,
    output logic                       o_valid,
    output logic [qnl_pkg::LENW-1:0]   o_root,
    output qnl_pkg::t_side_sq          o_side
);
    import qnl_pkg::*;

    logic [ISQ_STEPS-1:0] r_v;
    logic [SQW-1:0]       r_val  [ISQ_STEPS];
    logic [REMW-1:0]      r_rem  [ISQ_STEPS];
    logic [LENW-1:0]      r_root [ISQ_STEPS];
    t_side_sq             r_side [ISQ_STEPS];

    logic [REMW-1:0]      n_rem  [ISQ_STEPS];
    logic [LENW-1:0]      n_root [ISQ_STEPS];

    always_comb begin
        logic [SQW-1:0]  v;
        logic [REMW-1:0] pr;
        logic [LENW-1:0] proot;
        logic [REMW-1:0] sr;
        logic [REMW-1:0] trial;
        for (int k = 0; k < ISQ_STEPS; k++) begin
            if (k == 0) begin
                v     = i_val;
                pr    = '0;
                proot = '0;
            end else begin
                v     = r_val[k-1];
                pr    = r_rem[k-1];
                proot = r_root[k-1];
            end
            sr    = {pr[REMW-3:0], v[2*(ISQ_STEPS-1-k) +: 2]};
            trial = {proot, 2'b01};
            if (sr >= trial) begin
                n_rem[k]  = sr - trial;
                n_root[k] = {proot[LENW-2:0], 1'b1};
            end else begin
                n_rem[k]  = sr;
                n_root[k] = {proot[LENW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_ce) begin
            r_v <= {r_v[ISQ_STEPS-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            for (int k = 0; k < ISQ_STEPS; k++) begin
                r_rem[k]  <= n_rem[k];
                r_root[k] <= n_root[k];
                r_val[k]  <= (k == 0) ? i_val  : r_val[k-1];
                r_side[k] <= (k == 0) ? i_side : r_side[k-1];
            end
        end
    end

    assign o_valid = r_v[ISQ_STEPS-1];
    assign o_root  = r_root[ISQ_STEPS-1];
    assign o_side  = r_side[ISQ_STEPS-1];

endmodule

/* hdl/qnl_div.sv */
// Pipelined restoring divider for four lanes sharing one divisor, one quotient bit per stage.
module qnl_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_ce,
    input  logic                       i_valid,
    input  qnl_pkg::t_mags             i_mag,
    input  logic [qnl_pkg::LENW-1:0]   i_len,
    input  qnl_pkg::t_side_div         i_side,
    output logic                       o_valid,
    output qnl_pkg::t_quots            o_q,
    output logic [qnl_pkg::LENW-1:0]   o_len,
    output qnl_pkg::t_side_div         o_side
);
    import qnl_pkg::*;

    logic [QW-1:0]          r_v;
    logic [3:0][REMW-1:0]   r_rem  [QW];
    t_quots                 r_q    [QW];
    logic [LENW-1:0]        r_len  [QW];
    t_side_div              r_side [QW];

    logic [3:0][REMW-1:0]   n_rem  [QW];
    t_quots                 n_q    [QW];

    always_comb begin
        logic [LENW-1:0]      len;
        logic [3:0][REMW-1:0] pr;
        t_quots               pq;
        logic [REMW-1:0]      dv;
        logic [REMW-1:0]      sr;
        for (int k = 0; k < QW; k++) begin
            if (k == 0) begin
                len = i_len;
                for (int l = 0; l < 4; l++) begin
                    pr[l] = REMW'(i_mag[l]) + REMW'(i_len >> QW);
                end
                pq = '0;
            end else begin
                len = r_len[k-1];
                pr  = r_rem[k-1];
                pq  = r_q[k-1];
            end
            dv = {1'b0, len, 1'b0};
            for (int l = 0; l < 4; l++) begin
                sr = {pr[l][REMW-2:0], len[QW-1-k]};
                if (sr >= dv) begin
                    n_rem[k][l] = sr - dv;
                    n_q[k][l]   = {pq[l][QW-2:0], 1'b1};
                end else begin
                    n_rem[k][l] = sr;
                    n_q[k][l]   = {pq[l][QW-2:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_ce) begin
            r_v <= {r_v[QW-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            for (int k = 0; k < QW; k++) begin
                r_rem[k]  <= n_rem[k];
                r_q[k]    <= n_q[k];
                r_len[k]  <= (k == 0) ? i_len  : r_len[k-1];
                r_side[k] <= (k == 0) ? i_side : r_side[k-1];
            end
        end
    end

    assign o_valid = r_v[QW-1];
    assign o_q     = r_q[QW-1];
    assign o_len   = r_len[QW-1];
    assign o_side  = r_side[QW-1];

endmodule

/* hdl/quat_normalized_lerp_top.sv */
// Top level of the quaternion nlerp pipeline: blend, length, divide and output register.
//
//  channel | handshake                | payload
//  --------+--------------------------+------------------------------------------
//  input   | i_in_valid / o_in_ready  | i_from_x..w, i_to_x..w, i_blend_t
//  output  | o_out_valid / i_out_ready| o_out_x..w, o_degenerate
//
// One transaction per cycle unless the pipeline holds; 5 blend stages, 25 square root
// stages, 15 divider stages, output register.
// Reset clears all valid bits; no state beyond the pipeline.
// The whole pipeline holds while the output register is full and not taken.
module quat_normalized_lerp_top (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic signed [15:0]         i_from_x,
    input  logic signed [15:0]         i_from_y,
    input  logic signed [15:0]         i_from_z,
    input  logic signed [15:0]         i_from_w,
    input  logic signed [15:0]         i_to_x,
    input  logic signed [15:0]         i_to_y,
    input  logic signed [15:0]         i_to_z,
    input  logic signed [15:0]         i_to_w,
    input  logic [16:0]                i_blend_t,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic signed [15:0]         o_out_x,
    output logic signed [15:0]         o_out_y,
    output logic signed [15:0]         o_out_z,
    output logic signed [15:0]         o_out_w,
    output logic                       o_degenerate
);
    import qnl_pkg::*;

    logic ce;

    logic signed [CW-1:0] f [4];
    logic signed [CW-1:0] g [4];
    logic [TW-1:0]        w0;
    logic                 same;
    logic                 t_zero;

    logic                 r1_v, r2_v, r3_v, r4_v, r5_v;
    logic signed [PW-1:0] r1_p0 [4];
    logic signed [PW-1:0] r1_p1 [4];
    logic signed [2*CW-1:0] r1_dp [4];
    t_side_div            r1_s, r2_s, r3_s, r4_s, r5_s;
    logic signed [PW-1:0] r2_p0 [4];
    logic signed [PW-1:0] r2_p1 [4];
    logic                 r2_dneg;
    t_mags                r3_mag, r4_mag, r5_mag;
    logic [2*MAGW-1:0]    r4_sq [4];
    logic [SQW-1:0]       r5_sum;

    t_side_div            n1_s;
    logic signed [DW-1:0] n2_dot;
    t_mags                n3_mag;
    logic [3:0]           n3_neg;

    logic                 sq_v;
    logic [LENW-1:0]      sq_root;
    t_side_sq             sq_side;
    t_side_sq             sq_in;

    logic                 dv_v;
    t_quots               dv_q;
    logic [LENW-1:0]      dv_len;
    t_side_div            dv_s;

    logic                 r_out_valid;
    logic [3:0][CW-1:0]   r_out;
    logic                 r_degen;
    logic [3:0][CW-1:0]   n_out;
    logic                 n_degen;

    assign ce         = ~r_out_valid | i_out_ready;
    assign o_in_ready = ce;

    assign f[0] = i_from_x;
    assign f[1] = i_from_y;
    assign f[2] = i_from_z;
    assign f[3] = i_from_w;
    assign g[0] = i_to_x;
    assign g[1] = i_to_y;
    assign g[2] = i_to_z;
    assign g[3] = i_to_w;

    assign w0     = TW'(1 << WFB) - i_blend_t;
    assign same   = (f[0] == g[0]) && (f[1] == g[1]) && (f[2] == g[2]) && (f[3] == g[3]);
    assign t_zero = (i_blend_t == '0);

    always_comb begin
        n1_s.bypass = t_zero | i_blend_t[WFB] | same;
        n1_s.neg    = '0;
        for (int i = 0; i < 4; i++) begin
            n1_s.byp[i] = t_zero ? f[i] : g[i];
        end
    end

    always_comb begin
        n2_dot = '0;
        for (int i = 0; i < 4; i++) begin
            n2_dot = n2_dot + DW'(r1_dp[i]);
        end
    end

    always_comb begin
        logic signed [BW-1:0] b;
        logic [BW-1:0]        bm;
        logic [BMW-1:0]       rnd;
        for (int i = 0; i < 4; i++) begin
            b = r2_dneg ? (BW'(r2_p0[i]) - BW'(r2_p1[i])) : (BW'(r2_p0[i]) + BW'(r2_p1[i]));
            bm = b[BW-1] ? BW'(-b) : BW'(b);
            rnd = bm[BMW-1:0] + BMW'(1 << (SH - 1));
            n3_mag[i] = rnd[SH +: MAGW];
            n3_neg[i] = b[BW-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
            r5_v <= 1'b0;
        end else if (ce) begin
            r1_v <= i_in_valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
            r5_v <= r4_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            for (int i = 0; i < 4; i++) begin
                r1_p0[i] <= $signed({1'b0, w0}) * f[i];
                r1_p1[i] <= $signed({1'b0, i_blend_t}) * g[i];
                r1_dp[i] <= f[i] * g[i];
                r2_p0[i] <= r1_p0[i];
                r2_p1[i] <= r1_p1[i];
                r4_sq[i] <= r3_mag[i] * r3_mag[i];
            end
            r1_s    <= n1_s;
            r2_s    <= r1_s;
            r2_dneg <= n2_dot[DW-1];
            r3_s    <= '{bypass: r2_s.bypass, byp: r2_s.byp, neg: n3_neg};
            r3_mag  <= n3_mag;
            r4_s    <= r3_s;
            r4_mag  <= r3_mag;
            r5_s    <= r4_s;
            r5_mag  <= r4_mag;
            r5_sum  <= SQW'(r4_sq[0]) + SQW'(r4_sq[1]) + SQW'(r4_sq[2]) + SQW'(r4_sq[3]);
        end
    end

    assign sq_in = '{d: r5_s, mag: r5_mag};

    qnl_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (ce),
        .i_valid (r5_v),
        .i_val   (r5_sum),
        .i_side  (sq_in),
        .o_valid (sq_v),
        .o_root  (sq_root),
        .o_side  (sq_side)
    );

    qnl_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (ce),
        .i_valid (sq_v),
        .i_mag   (sq_side.mag),
        .i_len   (sq_root),
        .i_side  (sq_side.d),
        .o_valid (dv_v),
        .o_q     (dv_q),
        .o_len   (dv_len),
        .o_side  (dv_s)
    );

    always_comb begin
        n_degen = 1'b0;
        for (int i = 0; i < 4; i++) begin
            if (dv_s.bypass) begin
                n_out[i] = dv_s.byp[i];
            end else if (dv_len == '0) begin
                n_out[i] = '0;
                n_degen  = 1'b1;
            end else if (dv_s.neg[i]) begin
                n_out[i] = CW'(-$signed({1'b0, dv_q[i]}));
            end else begin
                n_out[i] = CW'(dv_q[i]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ce) begin
            r_out_valid <= dv_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_out   <= n_out;
            r_degen <= n_degen;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_x      = r_out[0];
    assign o_out_y      = r_out[1];
    assign o_out_z      = r_out[2];
    assign o_out_w      = r_out[3];
    assign o_degenerate = r_degen;

endmodule
